FILE: rtl/contiguous_unit_allocator_macros.svh
// Assertion helpers for the allocator.
`ifndef CONTIGUOUS_UNIT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_UNIT_ALLOCATOR_MACROS_SVH

// Implication checked on every rising clock edge, reset low disables.
`define CUA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define CUA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/cua_pkg.sv
// ----------------------------------------------------------------------------
// cua_pkg
// Shared types and codes of the contiguous unit allocator.
// ----------------------------------------------------------------------------
package cua_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_NEXT  = 2'd1;
  localparam logic [1:0] POL_BEST  = 2'd2;
  localparam logic [1:0] POL_WORST = 2'd3;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b00_0001,
    S_IDLE  = 6'b00_0010,
    S_SCAN  = 6'b00_0100,
    S_FIND  = 6'b00_1000,
    S_WRITE = 6'b01_0000,
    S_OUT   = 6'b10_0000
  } state_t;

endpackage

FILE: rtl/contiguous_unit_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_unit_allocator
// Contiguous run allocator over a unit owner map, first/next/best/worst fit.
// ----------------------------------------------------------------------------
// One item at a time. After reset a clearing pass empties the map before the
// first beat is taken. The map memory reads one unit per cycle (registered
// read data), and a single scan walks it once from unit 0 while tracking the
// current free hole. An allocate scans the whole map, picks the base, then
// writes unit_count entries one per cycle before the next beat can be taken.
// A free clears the owner's first run as the scan passes it and stops at its
// end. A request refused at the door (owner zero, or for an allocate a zero
// count or a count beyond the map) goes straight to the result state. The
// result sits in an output register; the next beat is taken while it waits,
// and the block only holds in its result state while an older result is
// still unread.
module contiguous_unit_allocator #(
  parameter int MAP_UNITS  = 128,
  parameter int OWNER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,      // [1:0] fit_policy
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // [15:0] owner_id, [23:16] unit_count
  input  logic        in_tuser,      // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata      // [1:0] status, [8:2] base_index
);
`include "contiguous_unit_allocator_macros.svh"

  localparam int AW = $clog2(MAP_UNITS);
  localparam int CW = AW + 1;

  logic                  cmd_in;
  logic [OWNER_BITS-1:0] owner_m;
  logic [7:0]            count_in;
  assign cmd_in   = in_tuser;
  assign owner_m  = OWNER_BITS'(in_tdata[15:0]);
  assign count_in = in_tdata[23:16];

  logic [OWNER_BITS-1:0] mem [MAP_UNITS];
  logic [OWNER_BITS-1:0] rd_r;
  logic                  we;
  logic [AW-1:0]         wa, ra;
  logic [OWNER_BITS-1:0] wd;

  cua_pkg::state_t state_r, state_nxt;
  logic [1:0]            pol_r;
  logic [AW-1:0]         nfp_r, nfp_nxt;
  logic                  cmd_r;
  logic [OWNER_BITS-1:0] own_r;
  logic [CW-1:0]         n_r;
  logic [CW-1:0]         idx_r, idx_nxt;     // scan counter (address stream)
  logic                  vld_r;              // rd_r holds unit idx_d_r
  logic [AW-1:0]         idx_d_r;
  logic [AW-1:0]         hs_r, hs_nxt;       // current hole start
  logic [CW-1:0]         hl_r, hl_nxt;       // current hole length
  logic                  fnd_r, fnd_nxt;
  logic [AW-1:0]         pk_r, pk_nxt;
  logic [CW-1:0]         pl_r, pl_nxt;
  logic                  fnd2_r, fnd2_nxt;   // next fit: start at or above pointer
  logic [AW-1:0]         pk2_r, pk2_nxt;
  logic [CW-1:0]         wc_r, wc_nxt;       // write cursor
  logic [CW-1:0]         we_end_r, we_end_nxt;
  logic [1:0]            st_r, st_nxt;
  logic [AW-1:0]         base_r, base_nxt;
  logic                  ov_r, ov_nxt;
  logic [15:0]           od_r, od_nxt;

  localparam logic [CW-1:0] MU = CW'(MAP_UNITS);

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  logic in_acc, cfg_acc, reject;
  assign cfg_ready  = (state_r == cua_pkg::S_IDLE) && !ov_r && !in_tvalid;
  assign in_tready  = (state_r == cua_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign reject = (owner_m == '0) ||
                  (cmd_in == cua_pkg::CMD_ALLOC &&
                   (count_in == 8'd0 || {24'd0, count_in} > 32'(MAP_UNITS)));

  // per-unit hole tracking terms
  logic          free_u, last_u, hole_end;
  logic [CW-1:0] run_len, hole_len, cand, run_end;
  logic [AW-1:0] hole_start, hole_base, pick;
  assign free_u     = (rd_r == '0);
  assign last_u     = ({1'b0, idx_d_r} == MU - 1'b1);
  assign run_len    = hl_r + 1'b1;
  assign hole_start = (hl_r == '0) ? idx_d_r : hs_r;
  assign hole_end   = !free_u || last_u;
  assign hole_len   = free_u ? run_len : hl_r;
  assign hole_base  = free_u ? hole_start : hs_r;
  // run of n ending at this unit starts here
  assign cand       = {1'b0, idx_d_r} + 1'b1 - n_r;
  assign pick       = (pol_r == cua_pkg::POL_NEXT && fnd2_r) ? pk2_r : pk_r;
  assign run_end    = {1'b0, pick} + n_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r; hs_nxt = hs_r; hl_nxt = hl_r; fnd_nxt = fnd_r;
    pk_nxt = pk_r; pl_nxt = pl_r; fnd2_nxt = fnd2_r; pk2_nxt = pk2_r;
    wc_nxt = wc_r; we_end_nxt = we_end_r; st_nxt = st_r; base_nxt = base_r;
    nfp_nxt = nfp_r; ov_nxt = ov_r; od_nxt = od_r;
    we = 1'b0; wa = wc_r[AW-1:0]; wd = own_r; ra = idx_r[AW-1:0];
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (state_r)
      cua_pkg::S_CLEAR: begin
        we = 1'b1; wa = idx_r[AW-1:0]; wd = '0;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == MU - 1'b1) state_nxt = cua_pkg::S_IDLE;
      end
      cua_pkg::S_IDLE: begin
        idx_nxt = '0; hl_nxt = '0; hs_nxt = '0; fnd_nxt = 1'b0; fnd2_nxt = 1'b0;
        pl_nxt = '0; pk_nxt = '0; pk2_nxt = '0; base_nxt = '0;
        if (in_acc) begin
          if (reject) begin
            st_nxt = (cmd_in == cua_pkg::CMD_FREE) ? cua_pkg::ST_NOT_FOUND :
                                                     cua_pkg::ST_NO_SPACE;
            state_nxt = cua_pkg::S_OUT;
          end else state_nxt = cua_pkg::S_SCAN;
        end
      end
      cua_pkg::S_SCAN: begin
        if (idx_r < MU) idx_nxt = idx_r + 1'b1;
        if (vld_r) begin
          if (cmd_r == cua_pkg::CMD_FREE) begin
            // clear the first run as it streams by
            if (rd_r == own_r) begin
              we = 1'b1; wa = idx_d_r; wd = '0;
              if (!fnd_r) begin
                fnd_nxt = 1'b1; base_nxt = idx_d_r;
              end
              if (last_u) begin
                st_nxt = cua_pkg::ST_DONE; state_nxt = cua_pkg::S_OUT;
              end
            end else if (fnd_r) begin
              st_nxt = cua_pkg::ST_DONE; state_nxt = cua_pkg::S_OUT;
            end else if (last_u) begin
              st_nxt = cua_pkg::ST_NOT_FOUND; state_nxt = cua_pkg::S_OUT;
            end
          end else begin
            if (free_u) begin
              hs_nxt = hole_start; hl_nxt = run_len;
            end else hl_nxt = '0;
            if (pol_r == cua_pkg::POL_FIRST || pol_r == cua_pkg::POL_NEXT) begin
              if (free_u && run_len >= n_r) begin
                if (!fnd_r) begin
                  fnd_nxt = 1'b1; pk_nxt = cand[AW-1:0];
                end
                if (!fnd2_r && cand >= {1'b0, nfp_r}) begin
                  fnd2_nxt = 1'b1; pk2_nxt = cand[AW-1:0];
                end
              end
            end else if (hole_end && hole_len >= n_r) begin
              // strict compares keep the lowest hole on ties
              if (!fnd_r ||
                  (pol_r == cua_pkg::POL_BEST  && hole_len < pl_r) ||
                  (pol_r == cua_pkg::POL_WORST && hole_len > pl_r)) begin
                fnd_nxt = 1'b1; pl_nxt = hole_len; pk_nxt = hole_base;
              end
            end
            if (last_u) state_nxt = cua_pkg::S_FIND;
          end
        end
      end
      cua_pkg::S_FIND: begin
        if (fnd_r) begin
          base_nxt = pick; wc_nxt = {1'b0, pick}; we_end_nxt = run_end;
          if (pol_r == cua_pkg::POL_NEXT)
            nfp_nxt = (run_end >= MU) ? '0 : run_end[AW-1:0];
          state_nxt = cua_pkg::S_WRITE;
        end else begin
          st_nxt = cua_pkg::ST_NO_SPACE; state_nxt = cua_pkg::S_OUT;
        end
      end
      cua_pkg::S_WRITE: begin
        we = 1'b1; wa = wc_r[AW-1:0]; wd = own_r;
        wc_nxt = wc_r + 1'b1;
        if (wc_r + 1'b1 == we_end_r) begin
          st_nxt = cua_pkg::ST_DONE; state_nxt = cua_pkg::S_OUT;
        end
      end
      cua_pkg::S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = {7'd0, (st_r == cua_pkg::ST_DONE) ? 7'(base_r) : 7'd0, st_r};
          state_nxt = cua_pkg::S_IDLE;
        end
      end
      default: state_nxt = cua_pkg::S_IDLE;
    endcase
  end

  // read valid tracking: the address issued last cycle lands in rd_r now
  logic rd_issue;
  assign rd_issue = (state_r == cua_pkg::S_SCAN) && (state_nxt == cua_pkg::S_SCAN) &&
                    (idx_r < MU);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cua_pkg::S_CLEAR; pol_r <= cua_pkg::POL_FIRST; nfp_r <= '0;
      idx_r <= '0; ov_r <= 1'b0; vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      vld_r   <= rd_issue;
      ov_r    <= ov_nxt;
      nfp_r   <= nfp_nxt;
      if (cfg_acc) pol_r <= cfg_data[1:0];
    end
    if (in_acc) begin
      cmd_r <= cmd_in;
      own_r <= owner_m;
      n_r   <= CW'(count_in);
    end
    idx_d_r <= idx_r[AW-1:0]; hs_r <= hs_nxt; hl_r <= hl_nxt; fnd_r <= fnd_nxt;
    pk_r <= pk_nxt; pl_r <= pl_nxt; fnd2_r <= fnd2_nxt; pk2_r <= pk2_nxt;
    wc_r <= wc_nxt; we_end_r <= we_end_nxt; st_r <= st_nxt; base_r <= base_nxt;
    od_r <= od_nxt;
  end

  `CUA_ASSERT_IMP(a_busy_not_ready, state_r != cua_pkg::S_IDLE, !in_tready)
  `CUA_ASSERT_IMP(a_fail_zero_base, out_tvalid && out_tdata[1:0] != cua_pkg::ST_DONE,
                  out_tdata[8:2] == 7'd0)
  `CUA_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `CUA_ASSERT_IMP(a_write_in_map, we, wa < AW'(MAP_UNITS - 1) || wa == AW'(MAP_UNITS - 1))

endmodule
